// ===== rtl/mlr_pkg.sv =====
// Shared types and codes for the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

    // Item command codes
    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    // Per-line stepping mode, chosen at load time
    typedef struct packed {
        logic steep;    // y is the major axis
        logic x_neg;    // x walks downwards
        logic y_neg;    // y walks downwards
        logic keep_gt;  // minor axis holds while decision > 0 (else while < 0)
    } t_line_mode;

endpackage

`default_nettype wire

// ===== rtl/mlr_setup.sv =====
// Line setup: octant selection, start decision and per-step increments.
`default_nettype none

module mlr_setup #(
    parameter int COORD_BITS = 11
) (
    input  wire logic [COORD_BITS-1:0]   i_start_x,
    input  wire logic [COORD_BITS-1:0]   i_start_y,
    input  wire logic [COORD_BITS-1:0]   i_end_x,
    input  wire logic [COORD_BITS-1:0]   i_end_y,
    output mlr_pkg::t_line_mode          o_mode,
    output logic signed [COORD_BITS+3:0] o_dec_init,
    output logic signed [COORD_BITS+3:0] o_inc_keep,
    output logic signed [COORD_BITS+3:0] o_inc_move
);

    localparam int DW = COORD_BITS + 4;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dx2;
    logic signed [DW-1:0] dy2;
    logic        [DW-1:0] abs_dx;
    logic        [DW-1:0] abs_dy;
    logic                 steep;
    logic        [1:0]    quad;

    assign dx  = $signed({{(DW-COORD_BITS){1'b0}}, i_end_x})
               - $signed({{(DW-COORD_BITS){1'b0}}, i_start_x});
    assign dy  = $signed({{(DW-COORD_BITS){1'b0}}, i_end_y})
               - $signed({{(DW-COORD_BITS){1'b0}}, i_start_y});
    assign dx2 = dx <<< 1;
    assign dy2 = dy <<< 1;

    assign abs_dx = (dx < 0) ? DW'(-dx) : DW'(dx);
    assign abs_dy = (dy < 0) ? DW'(-dy) : DW'(dy);
    assign steep  = !(abs_dy < abs_dx);

    // Quadrant, tested in order so that ties fall to the first match
    always_comb begin
        if (i_start_x <= i_end_x && i_start_y <= i_end_y) begin
            quad = 2'd0;
        end else if (i_start_x <= i_end_x && i_start_y >= i_end_y) begin
            quad = 2'd1;
        end else if (i_start_x >= i_end_x && i_start_y <= i_end_y) begin
            quad = 2'd2;
        end else begin
            quad = 2'd3;
        end
    end

    always_comb begin
        o_mode.steep   = steep;
        o_mode.x_neg   = quad[1];
        o_mode.y_neg   = quad[0];
        o_mode.keep_gt = 1'b0;
        o_dec_init     = '0;
        o_inc_keep     = '0;
        o_inc_move     = '0;
        case ({steep, quad})
            3'd0: begin
                o_dec_init = dy2 - dx;
                o_inc_keep = dy2;
                o_inc_move = dy2 - dx2;
            end
            3'd4: begin
                o_mode.keep_gt = 1'b1;
                o_dec_init     = dy - dx2;
                o_inc_keep     = -dx2;
                o_inc_move     = dy2 - dx2;
            end
            3'd1: begin
                o_mode.keep_gt = 1'b1;
                o_dec_init     = dy2 + dx;
                o_inc_keep     = dy2;
                o_inc_move     = dy2 + dx2;
            end
            3'd5: begin
                o_dec_init = dy + dx2;
                o_inc_keep = dx2;
                o_inc_move = dy2 + dx2;
            end
            3'd2: begin
                o_mode.keep_gt = 1'b1;
                o_dec_init     = -dy2 - dx;
                o_inc_keep     = -dy2;
                o_inc_move     = -dy2 - dx2;
            end
            3'd6: begin
                o_dec_init = -dy - dx2;
                o_inc_keep = -dx2;
                o_inc_move = -dy2 - dx2;
            end
            3'd3: begin
                o_dec_init = -dy2 + dx;
                o_inc_keep = -dy2;
                o_inc_move = dx2 - dy2;
            end
            default: begin
                o_mode.keep_gt = 1'b1;
                o_dec_init     = -dy + dx2;
                o_inc_keep     = dx2;
                o_inc_move     = dx2 - dy2;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mlr_step.sv =====
// One midpoint step: end test, decision update and coordinate advance.
`default_nettype none

module mlr_step #(
    parameter int COORD_BITS = 11
) (
    input  wire mlr_pkg::t_line_mode          i_mode,
    input  wire logic [COORD_BITS-1:0]        i_cur_x,
    input  wire logic [COORD_BITS-1:0]        i_cur_y,
    input  wire logic [COORD_BITS-1:0]        i_stop_major,
    input  wire logic signed [COORD_BITS+3:0] i_dec,
    input  wire logic signed [COORD_BITS+3:0] i_inc_keep,
    input  wire logic signed [COORD_BITS+3:0] i_inc_move,
    output logic                              o_last,
    output logic [COORD_BITS-1:0]             o_next_x,
    output logic [COORD_BITS-1:0]             o_next_y,
    output logic signed [COORD_BITS+3:0]      o_next_dec
);

    logic keep;
    logic move_x;
    logic move_y;

    assign o_last = i_mode.steep ? (i_cur_y == i_stop_major) : (i_cur_x == i_stop_major);

    // Minor axis holds only on the strict test, so a zero decision moves it under either test
    assign keep   = i_mode.keep_gt ? (i_dec > 0) : (i_dec < 0);
    assign move_x = i_mode.steep ? !keep : 1'b1;
    assign move_y = i_mode.steep ? 1'b1 : !keep;

    assign o_next_dec = i_dec + (keep ? i_inc_keep : i_inc_move);

    always_comb begin
        o_next_x = i_cur_x;
        o_next_y = i_cur_y;
        if (move_x) begin
            o_next_x = i_mode.x_neg ? i_cur_x - 1'b1 : i_cur_x + 1'b1;
        end
        if (move_y) begin
            o_next_y = i_mode.y_neg ? i_cur_y - 1'b1 : i_cur_y + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer_core.sv =====
// An input beat is registered in the input stage and its pixel in the output register.
// Throughput: one beat per cycle while the output is not stalled; the line state (decision,
// position) is updated every beat, so consecutive step beats stream one pixel per clock.
// Load beats and steps with no active line pass through and produce no output beat.
// Reset (i_rst_n low, synchronous) empties both stages and drops any active line.
`default_nettype none

module midpoint_line_rasterizer_core #(
    parameter int COORD_BITS = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [0:0]            i_cmd,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic                       o_last_pixel
);

    localparam int DW = COORD_BITS + 4;

    // Input stage
    logic                  r_in_valid;
    mlr_pkg::t_cmd         r_cmd;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [COORD_BITS-1:0] r_end_x;
    logic [COORD_BITS-1:0] r_end_y;

    // Line state
    logic                  r_active;
    mlr_pkg::t_line_mode   r_mode;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [COORD_BITS-1:0] r_stop_major;
    logic signed [DW-1:0]  r_dec;
    logic signed [DW-1:0]  r_inc_keep;
    logic signed [DW-1:0]  r_inc_move;

    // Output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y;
    logic                  r_last;

    logic                  slot_free;
    logic                  in_fire;
    logic                  proc;
    logic                  proc_load;
    logic                  proc_emit;

    mlr_pkg::t_line_mode   setup_mode;
    logic signed [DW-1:0]  setup_dec;
    logic signed [DW-1:0]  setup_inc_keep;
    logic signed [DW-1:0]  setup_inc_move;

    logic                  step_last;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic signed [DW-1:0]  step_dec;

    logic                  n_active;
    mlr_pkg::t_line_mode   n_mode;
    logic [COORD_BITS-1:0] n_cur_x;
    logic [COORD_BITS-1:0] n_cur_y;
    logic [COORD_BITS-1:0] n_stop_major;
    logic signed [DW-1:0]  n_dec;
    logic signed [DW-1:0]  n_inc_keep;
    logic signed [DW-1:0]  n_inc_move;

    // Handshake: the output register frees when empty or when its beat is taken;
    // the input stage frees when it is empty or when it can move on into that slot.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || slot_free;
    assign in_fire    = i_in_valid && o_in_ready;

    assign proc      = r_in_valid && slot_free;
    assign proc_load = proc && (r_cmd == mlr_pkg::CMD_LOAD);
    assign proc_emit = proc && (r_cmd == mlr_pkg::CMD_STEP) && r_active;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x  (r_start_x),
        .i_start_y  (r_start_y),
        .i_end_x    (r_end_x),
        .i_end_y    (r_end_y),
        .o_mode     (setup_mode),
        .o_dec_init (setup_dec),
        .o_inc_keep (setup_inc_keep),
        .o_inc_move (setup_inc_move)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_mode       (r_mode),
        .i_cur_x      (r_cur_x),
        .i_cur_y      (r_cur_y),
        .i_stop_major (r_stop_major),
        .i_dec        (r_dec),
        .i_inc_keep   (r_inc_keep),
        .i_inc_move   (r_inc_move),
        .o_last       (step_last),
        .o_next_x     (step_x),
        .o_next_y     (step_y),
        .o_next_dec   (step_dec)
    );

    // Line state update: a load replaces the line, a step advances it or ends it
    always_comb begin
        n_active     = r_active;
        n_mode       = r_mode;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_stop_major = r_stop_major;
        n_dec        = r_dec;
        n_inc_keep   = r_inc_keep;
        n_inc_move   = r_inc_move;
        if (proc_load) begin
            n_active     = 1'b1;
            n_mode       = setup_mode;
            n_cur_x      = r_start_x;
            n_cur_y      = r_start_y;
            n_stop_major = setup_mode.steep ? r_end_y : r_end_x;
            n_dec        = setup_dec;
            n_inc_keep   = setup_inc_keep;
            n_inc_move   = setup_inc_move;
        end else if (proc_emit) begin
            if (step_last) begin
                n_active = 1'b0;
            end else begin
                n_cur_x = step_x;
                n_cur_y = step_y;
                n_dec   = step_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the input stage until it can be processed
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_active <= n_active;
            // Drop the output beat once taken; refill only when a pixel is due
            if (slot_free) begin
                r_out_valid <= proc_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd     <= mlr_pkg::t_cmd'(i_cmd);
            r_start_x <= i_start_x;
            r_start_y <= i_start_y;
            r_end_x   <= i_end_x;
            r_end_y   <= i_end_y;
        end
        r_mode       <= n_mode;
        r_cur_x      <= n_cur_x;
        r_cur_y      <= n_cur_y;
        r_stop_major <= n_stop_major;
        r_dec        <= n_dec;
        r_inc_keep   <= n_inc_keep;
        r_inc_move   <= n_inc_move;
        if (proc_emit) begin
            r_pixel_x <= r_cur_x;
            r_pixel_y <= r_cur_y;
            r_last    <= step_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last;

    // A processed load always leaves a line active
    a_load_activates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_load |=> r_active)
        else $error("load did not activate a line");

    // The final pixel of a line ends it
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_emit && step_last) |=> (!r_active && r_out_valid && r_last))
        else $error("last pixel did not end the line");

    // A step with no active line produces no beat
    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_cmd == mlr_pkg::CMD_STEP) && !r_active) |=> !r_out_valid)
        else $error("step without a line produced a pixel");

    // On a shallow line x moves by exactly one per emitted non-final pixel
    a_major_x_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_emit && !step_last && !r_mode.steep) |=>
            ((r_cur_x == $past(r_cur_x) + 1'b1) || (r_cur_x == $past(r_cur_x) - 1'b1)))
        else $error("major x coordinate did not advance by one");

    // On a steep line y moves by exactly one per emitted non-final pixel
    a_major_y_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_emit && !step_last && r_mode.steep) |=>
            ((r_cur_y == $past(r_cur_y) + 1'b1) || (r_cur_y == $past(r_cur_y) - 1'b1)))
        else $error("major y coordinate did not advance by one");

endmodule

`default_nettype wire
